@@ hdl/nrle_pkg.sv @@
// Types, constants and helper functions shared by the nibble RLE pixel decoder.
// No dependencies; compile this file first.
package nrle_pkg;

    localparam int PIX_W      = 16;
    localparam int REP_W      = 29;
    localparam int ACC_W      = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_TONE_WIDTH   = 3'd0;
    localparam t_cfg_idx CFG_COLOR_SHIFT  = 3'd1;
    localparam t_cfg_idx CFG_COLOR_WIDTH  = 3'd2;
    localparam t_cfg_idx CFG_PENCIL_SHIFT = 3'd3;
    localparam t_cfg_idx CFG_PENCIL_WIDTH = 3'd4;
    localparam t_cfg_idx CFG_START_ATTR   = 3'd5;

    // Configuration reset values
    localparam logic [2:0]  RST_TONE_WIDTH   = 3'd4;
    localparam logic [3:0]  RST_COLOR_SHIFT  = 4'd4;
    localparam logic [4:0]  RST_COLOR_WIDTH  = 5'd7;
    localparam logic [3:0]  RST_PENCIL_SHIFT = 4'd11;
    localparam logic [4:0]  RST_PENCIL_WIDTH = 5'd5;
    localparam logic [15:0] RST_START_ATTR   = 16'h0000;

    // Nibble codes
    localparam logic [3:0] NIB_PREFIX   = 4'hF;
    localparam logic [3:0] CMD_ONE_MAX  = 4'h0;
    localparam logic [3:0] CMD_RUN_MAX  = 4'h7;
    localparam logic [3:0] CMD_CLR_COL  = 4'h8;
    localparam logic [3:0] CMD_CLR_PEN  = 4'h9;
    localparam logic [3:0] CMD_SET_COL1 = 4'hA;
    localparam logic [3:0] CMD_SET_PEN1 = 4'hB;
    localparam logic [3:0] CMD_SET_COL2 = 4'hC;
    localparam logic [3:0] CMD_SET_PEN2 = 4'hD;
    localparam logic [3:0] CMD_END_PIX  = 4'hE;
    localparam logic [3:0] SEL_END      = 4'h0;
    localparam logic [3:0] SEL_RAW      = 4'h1;
    localparam logic [2:0] RAW_DIGITS   = 3'd4;

    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_CMD,
        MODE_COUNT,
        MODE_SETCOL,
        MODE_SETPEN,
        MODE_ESC,
        MODE_RAW
    } t_mode;

    typedef struct packed {
        logic [2:0]  tone_width;
        logic [3:0]  color_shift;
        logic [4:0]  color_width;
        logic [3:0]  pencil_shift;
        logic [4:0]  pencil_width;
        logic [15:0] start_attribute;
    } t_cfg;

    typedef struct packed {
        t_mode             mode;
        logic [2:0]        digits_left;
        logic [ACC_W-1:0]  acc;
        logic [PIX_W-1:0]  attr;
    } t_parse;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [REP_W-1:0] repeat_count;
        logic             row_done;
        logic             decode_error;
        logic             last_of_item;
    } t_result;

    // Results of one byte: one or two
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_pair;

    // Outcome of decoding one nibble
    typedef struct packed {
        t_parse  st;
        logic    emit;
        logic    ends;
        t_result res;
    } t_nib;

    // Field mask; a width of 16 or more covers the whole word
    function automatic logic [PIX_W-1:0] field_mask(input logic [4:0] width,
                                                    input logic [3:0] shift);
        logic [PIX_W:0] ones;
        ones = (17'd1 << width[3:0]) - 17'd1;
        if (width[4]) begin
            ones = 17'h0FFFF;
        end
        return ones[PIX_W-1:0] << shift;
    endfunction

endpackage

@@ hdl/nrle_channels.sv @@
// Handshake channel interfaces of the nibble RLE pixel decoder.
// Depends on nrle_pkg for field widths.
interface nrle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface nrle_pix_if;
    import nrle_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic [REP_W-1:0] repeat_count;
    logic             row_done;
    logic             decode_error;
    logic             last_of_item;

    modport source (output valid, output pixel_value, output repeat_count,
                    output row_done, output decode_error, output last_of_item,
                    input ready);
    modport sink   (input valid, input pixel_value, input repeat_count,
                    input row_done, input decode_error, input last_of_item,
                    output ready);
endinterface

interface nrle_cfg_if;
    import nrle_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ hdl/nibble_rle_pixel16_decoder_top.sv @@
// Top level of the nibble RLE pixel decoder: front end, result queue, back end.
// Depends on nrle_pkg, nrle_channels, nrle_front, nrle_fifo, nrle_back.
//
// Usage:
//   i_byte carries compressed bytes; each byte is decoded high nibble first
//   and gives zero, one or two results. o_pix carries results: a pixel with
//   its repeat count, end-of-row and error flags, and a flag on the last
//   result of each byte. i_cfg writes the six configuration registers; it is
//   always ready. Write it only while the decoder is idle.
//   A byte accepted on i_byte passes through the queue, the pair register and
//   the output register before its first result shows on o_pix. The front
//   end takes one byte per cycle while the queue is not full, both nibbles
//   decoded in the same cycle; the output stage sends one result per cycle
//   while o_pix.ready is high. FIFO_DEPTH entries of queue let the front keep
//   accepting while the output drains or stalls. When o_pix.ready is low the
//   output holds; i_byte.ready drops only once the queue is full.
//   Reset loads the default configuration, empties queue and output stage,
//   and starts parsing with a plain nibble on attribute 0.
module nibble_rle_pixel16_decoder_top
    import nrle_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nrle_byte_if.sink   i_byte,
    nrle_cfg_if.sink    i_cfg,
    nrle_pix_if.source  o_pix
);

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_pair push_pair;
    t_pair pop_pair;

    nrle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_pair  (push_pair)
    );

    nrle_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (push_pair),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_pair  (pop_pair)
    );

    nrle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_pair  (pop_pair),
        .o_pop   (pop),
        .o_pix   (o_pix)
    );

endmodule

@@ hdl/nrle_front.sv @@
// Front end: accepts compressed bytes, decodes both nibbles of a byte in the same cycle,
// holds the parse state and configuration. Depends on nrle_pkg, nrle_channels.
module nrle_front
    import nrle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    nrle_byte_if.sink   i_byte,
    nrle_cfg_if.sink    i_cfg,
    input  logic        i_full,
    output logic        o_push,
    output t_pair       o_pair
);

    t_cfg   r_cfg, n_cfg;
    t_parse r_st, n_st;
    t_nib   nib_hi, nib_lo;
    logic   accept;
    logic   emit_lo;

    // Decode one nibble against the current parse state
    function automatic t_nib decode_nibble(input t_parse st, input t_cfg cfg,
                                           input logic [3:0] n);
        t_nib             o;
        logic [3:0]       mt;
        logic [PIX_W-1:0] full;
        logic [PIX_W-1:0] cmask;
        logic [PIX_W-1:0] pmask;
        logic [ACC_W-1:0] acc_n;
        logic [2:0]       dl_n;
        mt = (cfg.tone_width >= 3'd4) ? 4'hF
                                      : 4'((5'd1 << cfg.tone_width[1:0]) - 5'd1);
        full  = st.attr | {12'h000, mt};
        cmask = field_mask(cfg.color_width, cfg.color_shift);
        pmask = field_mask(cfg.pencil_width, cfg.pencil_shift);
        acc_n = {st.acc[ACC_W-5:0], n};
        dl_n  = st.digits_left - 3'd1;
        o      = '0;
        o.st   = st;
        unique case (st.mode)
            MODE_CMD: begin
                o.st.mode = MODE_PLAIN;
                o.st.acc  = '0;
                priority if (n == CMD_ONE_MAX) begin
                    o.emit = 1'b1;
                    o.res.pixel_value  = full;
                    o.res.repeat_count = 29'd1;
                end else if (n <= CMD_RUN_MAX) begin
                    o.st.mode        = MODE_COUNT;
                    o.st.digits_left = n[2:0];
                end else if (n == CMD_CLR_COL) begin
                    o.st.attr = st.attr & ~cmask;
                end else if (n == CMD_CLR_PEN) begin
                    o.st.attr = st.attr & ~pmask;
                end else if (n == CMD_SET_COL1 || n == CMD_SET_COL2) begin
                    o.st.mode        = MODE_SETCOL;
                    o.st.digits_left = (n == CMD_SET_COL1) ? 3'd1 : 3'd2;
                end else if (n == CMD_SET_PEN1 || n == CMD_SET_PEN2) begin
                    o.st.mode        = MODE_SETPEN;
                    o.st.digits_left = (n == CMD_SET_PEN1) ? 3'd1 : 3'd2;
                end else if (n == CMD_END_PIX) begin
                    o.emit = 1'b1;
                    o.ends = 1'b1;
                    o.res.pixel_value  = full;
                    o.res.repeat_count = 29'd1;
                    o.res.row_done     = 1'b1;
                end else begin
                    o.st.mode = MODE_ESC;
                end
            end
            MODE_COUNT, MODE_SETCOL, MODE_SETPEN, MODE_RAW: begin
                o.st.acc         = acc_n;
                o.st.digits_left = dl_n;
                if (dl_n == 3'd0) begin
                    o.st.mode = MODE_PLAIN;
                    o.st.acc  = '0;
                    unique case (st.mode)
                        MODE_COUNT: begin
                            o.emit = 1'b1;
                            o.res.pixel_value  = full;
                            o.res.repeat_count = {1'b0, acc_n} + 29'd1;
                        end
                        MODE_RAW: begin
                            o.emit = 1'b1;
                            o.ends = 1'b1;
                            o.res.pixel_value  = acc_n[PIX_W-1:0];
                            o.res.repeat_count = 29'd1;
                            o.res.row_done     = 1'b1;
                        end
                        MODE_SETCOL: begin
                            o.st.attr = (st.attr & ~cmask)
                                      | (acc_n[PIX_W-1:0] << cfg.color_shift);
                        end
                        default: begin
                            o.st.attr = (st.attr & ~pmask)
                                      | (acc_n[PIX_W-1:0] << cfg.pencil_shift);
                        end
                    endcase
                end
            end
            MODE_ESC: begin
                o.st.mode = MODE_PLAIN;
                if (n == SEL_RAW) begin
                    o.st.mode        = MODE_RAW;
                    o.st.digits_left = RAW_DIGITS;
                    o.st.acc         = '0;
                end else begin
                    // Empty row end or bad selector: both close the row
                    o.emit = 1'b1;
                    o.ends = 1'b1;
                    o.res.row_done     = 1'b1;
                    o.res.decode_error = (n != SEL_END);
                end
            end
            default: begin
                o.st.mode = MODE_PLAIN;
                if (n == NIB_PREFIX) begin
                    o.st.mode = MODE_CMD;
                end else begin
                    o.emit = 1'b1;
                    o.res.pixel_value  = st.attr | {12'h000, n};
                    o.res.repeat_count = 29'd1;
                end
            end
        endcase
        // Restart the row after end or error
        if (o.ends) begin
            o.st.mode        = MODE_PLAIN;
            o.st.digits_left = '0;
            o.st.acc         = '0;
            o.st.attr        = cfg.start_attribute;
        end
        return o;
    endfunction

    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = !i_full;
    assign accept       = i_byte.valid && !i_full;

    // Decode high nibble, then low nibble from the updated state
    assign nib_hi  = decode_nibble(r_st, r_cfg, i_byte.in_byte[7:4]);
    assign nib_lo  = decode_nibble(nib_hi.st, r_cfg, i_byte.in_byte[3:0]);
    assign emit_lo = nib_lo.emit && !nib_hi.ends;

    // Pack the results of this byte and mark the last one
    always_comb begin
        o_pair        = '0;
        o_pair.two    = nib_hi.emit && emit_lo;
        o_pair.first  = nib_hi.emit ? nib_hi.res : nib_lo.res;
        o_pair.second = nib_lo.res;
        if (o_pair.two) begin
            o_pair.second.last_of_item = 1'b1;
        end else begin
            o_pair.first.last_of_item = 1'b1;
        end
        o_push = accept && (nib_hi.emit || emit_lo);
    end

    // Next parse state and configuration
    always_comb begin
        n_st  = r_st;
        n_cfg = r_cfg;
        if (accept) begin
            n_st = nib_hi.ends ? nib_hi.st : nib_lo.st;
        end
        if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_TONE_WIDTH:   n_cfg.tone_width   = i_cfg.wr_data[2:0];
                CFG_COLOR_SHIFT:  n_cfg.color_shift  = i_cfg.wr_data[3:0];
                CFG_COLOR_WIDTH:  n_cfg.color_width  = i_cfg.wr_data[4:0];
                CFG_PENCIL_SHIFT: n_cfg.pencil_shift = i_cfg.wr_data[3:0];
                CFG_PENCIL_WIDTH: n_cfg.pencil_width = i_cfg.wr_data[4:0];
                CFG_START_ATTR: begin
                    n_cfg.start_attribute = i_cfg.wr_data;
                    n_st.attr             = i_cfg.wr_data;
                end
                default: ;
            endcase
        end
    end

    // Hold state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tone_width      <= RST_TONE_WIDTH;
            r_cfg.color_shift     <= RST_COLOR_SHIFT;
            r_cfg.color_width     <= RST_COLOR_WIDTH;
            r_cfg.pencil_shift    <= RST_PENCIL_SHIFT;
            r_cfg.pencil_width    <= RST_PENCIL_WIDTH;
            r_cfg.start_attribute <= RST_START_ATTR;
            r_st.mode             <= MODE_PLAIN;
            r_st.digits_left      <= '0;
            r_st.acc              <= '0;
            r_st.attr             <= RST_START_ATTR;
        end else begin
            r_cfg <= n_cfg;
            r_st  <= n_st;
        end
    end

endmodule

@@ hdl/nrle_fifo.sv @@
// Result queue between front and back end; one entry holds the results of one byte.
// Depends on nrle_pkg.
module nrle_fifo
    import nrle_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_pair,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_pair o_pair
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_pair            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_pair  = r_mem[r_rd];

    // Advance pointers and occupancy
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

endmodule

@@ hdl/nrle_back.sv @@
// Back end: takes result pairs from the queue and sends them one per cycle while
// o_pix.ready is high, through a registered output stage. Depends on nrle_pkg, nrle_channels.
module nrle_back
    import nrle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_pair       i_pair,
    output logic        o_pop,
    nrle_pix_if.source  o_pix
);

    t_pair   r_pair, n_pair;
    logic    r_pv, n_pv;
    logic    r_sel, n_sel;
    t_result r_out, n_out;
    logic    r_ov, n_ov;
    logic    out_free;

    assign out_free = !r_ov || o_pix.ready;

    // Feed the output stage and refill the pair register
    always_comb begin
        n_pair = r_pair;
        n_pv   = r_pv;
        n_sel  = r_sel;
        n_out  = r_out;
        n_ov   = r_ov;
        o_pop  = 1'b0;
        if (out_free) begin
            if (r_pv) begin
                n_ov  = 1'b1;
                n_out = r_sel ? r_pair.second : r_pair.first;
                if (!r_sel && r_pair.two) begin
                    n_sel = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
            end else begin
                n_ov = 1'b0;
            end
        end
        if (!i_empty && !n_pv) begin
            o_pop  = 1'b1;
            n_pv   = 1'b1;
            n_sel  = 1'b0;
            n_pair = i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_sel <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_pv  <= n_pv;
            r_sel <= n_sel;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair <= n_pair;
        r_out  <= n_out;
    end

    assign o_pix.valid        = r_ov;
    assign o_pix.pixel_value  = r_out.pixel_value;
    assign o_pix.repeat_count = r_out.repeat_count;
    assign o_pix.row_done     = r_out.row_done;
    assign o_pix.decode_error = r_out.decode_error;
    assign o_pix.last_of_item = r_out.last_of_item;

endmodule

@@ hdl/nrle_checker.sv @@
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on nrle_pkg and nibble_rle_pixel16_decoder_top.
module nrle_checker
    import nrle_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input logic [REP_W-1:0] i_repeat_count,
    input logic             i_row_done,
    input logic             i_decode_error,
    input logic             i_last_of_item
);

    // Hold a stalled transaction
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result valid dropped while stalled");

    // Output stage comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    // Row end drops the rest of the byte, so it is always the last result
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_row_done |-> i_last_of_item)
        else $error("row end not marked last of byte");

    // Only an empty row end or an error carries no pixels
    a_zero_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_repeat_count == '0 || i_decode_error) |-> i_row_done)
        else $error("zero-count or error result without row end");

endmodule

bind nibble_rle_pixel16_decoder_top nrle_checker u_nrle_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_pix.valid),
    .i_ready        (o_pix.ready),
    .i_repeat_count (o_pix.repeat_count),
    .i_row_done     (o_pix.row_done),
    .i_decode_error (o_pix.decode_error),
    .i_last_of_item (o_pix.last_of_item)
);

@@ bench/nrle_decode_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the nibble RLE pixel decoder: mirrors the register file and parser state,
// predicts the results of every accepted byte and compares them in order.
// Depends on nrle_pkg.
module nrle_decode_checker
    import nrle_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_byte_valid,
    input  logic                  i_byte_ready,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_pix_valid,
    input  logic                  i_pix_ready,
    input  logic [PIX_W-1:0]      i_pixel_value,
    input  logic [REP_W-1:0]      i_repeat_count,
    input  logic                  i_row_done,
    input  logic                  i_decode_error,
    input  logic                  i_last_of_item,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    // Mirrored registers and parser state
    t_cfg             regs_q;
    logic [PIX_W-1:0] attr_q;
    t_mode            mode_q;
    logic [2:0]       digits_q;
    logic [ACC_W-1:0] acc_q;

    // Results still owed by the decoder, oldest first
    t_result pixels_owed[$];

    int fail_count = 0;
    int checked_n  = 0;
    int pending_n  = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;
    assign o_checked    = checked_n;

    // Bits covered by a field; widths of 16 and up cover the whole word
    function automatic logic [PIX_W-1:0] field_bits(input logic [4:0] width,
                                                    input logic [3:0] shift);
        logic [31:0] ones;
        logic [31:0] placed;
        ones   = (width >= 5'd16) ? 32'h0000_FFFF : ((32'd1 << width) - 32'd1);
        placed = ones << shift;
        return placed[PIX_W-1:0];
    endfunction

    function automatic logic [3:0] peak_tone();
        logic [4:0] ones;
        ones = (5'd1 << regs_q.tone_width) - 5'd1;
        return (regs_q.tone_width >= 3'd4) ? 4'hF : ones[3:0];
    endfunction

    function automatic t_result make_result(input logic [PIX_W-1:0] pix,
                                            input logic [REP_W-1:0] rep,
                                            input logic done, input logic err);
        t_result r;
        r.pixel_value  = pix;
        r.repeat_count = rep;
        r.row_done     = done;
        r.decode_error = err;
        r.last_of_item = 1'b0;
        return r;
    endfunction

    // Reload the attribute and parse from a plain nibble again
    task automatic restart_row();
        attr_q   = regs_q.start_attribute;
        mode_q   = MODE_PLAIN;
        digits_q = '0;
        acc_q    = '0;
    endtask

    // Merge a field value into the attribute without clipping it to the field
    task automatic merge_field(input logic [4:0] width, input logic [3:0] shift);
        logic [31:0] moved;
        moved  = {4'd0, acc_q} << shift;
        attr_q = (attr_q & ~field_bits(width, shift)) | moved[PIX_W-1:0];
    endtask

    task automatic decode_nibble(input logic [3:0] nib, output logic got,
                                 output logic ended, output t_result res);
        logic [PIX_W-1:0] full;
        full  = attr_q | {12'd0, peak_tone()};
        got   = 1'b0;
        ended = 1'b0;
        res   = '0;
        case (mode_q)
            MODE_CMD: begin
                mode_q = MODE_PLAIN;
                acc_q  = '0;
                if (nib == CMD_ONE_MAX) begin
                    got = 1'b1;
                    res = make_result(full, 29'd1, 1'b0, 1'b0);
                end else if (nib <= CMD_RUN_MAX) begin
                    mode_q   = MODE_COUNT;
                    digits_q = nib[2:0];
                end else if (nib == CMD_CLR_COL) begin
                    attr_q = attr_q & ~field_bits(regs_q.color_width, regs_q.color_shift);
                end else if (nib == CMD_CLR_PEN) begin
                    attr_q = attr_q & ~field_bits(regs_q.pencil_width, regs_q.pencil_shift);
                end else if (nib == CMD_SET_COL1 || nib == CMD_SET_COL2) begin
                    mode_q   = MODE_SETCOL;
                    digits_q = (nib == CMD_SET_COL1) ? 3'd1 : 3'd2;
                end else if (nib == CMD_SET_PEN1 || nib == CMD_SET_PEN2) begin
                    mode_q   = MODE_SETPEN;
                    digits_q = (nib == CMD_SET_PEN1) ? 3'd1 : 3'd2;
                end else if (nib == CMD_END_PIX) begin
                    got   = 1'b1;
                    ended = 1'b1;
                    res   = make_result(full, 29'd1, 1'b1, 1'b0);
                    restart_row();
                end else begin
                    mode_q = MODE_ESC;
                end
            end
            MODE_COUNT, MODE_SETCOL, MODE_SETPEN, MODE_RAW: begin
                acc_q    = {acc_q[ACC_W-5:0], nib};
                digits_q = digits_q - 3'd1;
                if (digits_q == 3'd0) begin
                    case (mode_q)
                        MODE_COUNT: begin
                            got    = 1'b1;
                            res    = make_result(full, {1'b0, acc_q} + 29'd1, 1'b0, 1'b0);
                            mode_q = MODE_PLAIN;
                            acc_q  = '0;
                        end
                        MODE_RAW: begin
                            got   = 1'b1;
                            ended = 1'b1;
                            res   = make_result(acc_q[PIX_W-1:0], 29'd1, 1'b1, 1'b0);
                            restart_row();
                        end
                        default: begin
                            if (mode_q == MODE_SETCOL) begin
                                merge_field(regs_q.color_width, regs_q.color_shift);
                            end else begin
                                merge_field(regs_q.pencil_width, regs_q.pencil_shift);
                            end
                            mode_q = MODE_PLAIN;
                            acc_q  = '0;
                        end
                    endcase
                end
            end
            MODE_ESC: begin
                if (nib == SEL_RAW) begin
                    mode_q   = MODE_RAW;
                    digits_q = RAW_DIGITS;
                    acc_q    = '0;
                end else begin
                    got   = 1'b1;
                    ended = 1'b1;
                    res   = make_result('0, '0, 1'b1, nib != SEL_END);
                    restart_row();
                end
            end
            default: begin
                mode_q = MODE_PLAIN;
                if (nib == NIB_PREFIX) begin
                    mode_q = MODE_CMD;
                end else begin
                    got = 1'b1;
                    res = make_result(attr_q | {12'd0, nib}, 29'd1, 1'b0, 1'b0);
                end
            end
        endcase
    endtask

    // Decode both nibbles of a byte, stop at a row end, flag the last result
    task automatic predict_byte(input logic [7:0] value);
        t_result made [2];
        t_result res;
        logic    got;
        logic    ended;
        int      n;
        n     = 0;
        ended = 1'b0;
        for (int i = 0; i < 2 && !ended; i++) begin
            decode_nibble(i == 0 ? value[7:4] : value[3:0], got, ended, res);
            if (got) begin
                made[n] = res;
                n++;
            end
        end
        if (n > 0) begin
            made[n-1].last_of_item = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            pixels_owed.push_back(made[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Track register writes, predict accepted bytes, score accepted results
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            regs_q.tone_width      = RST_TONE_WIDTH;
            regs_q.color_shift     = RST_COLOR_SHIFT;
            regs_q.color_width     = RST_COLOR_WIDTH;
            regs_q.pencil_shift    = RST_PENCIL_SHIFT;
            regs_q.pencil_width    = RST_PENCIL_WIDTH;
            regs_q.start_attribute = RST_START_ATTR;
            restart_row();
            pixels_owed.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TONE_WIDTH:   regs_q.tone_width   = i_cfg_data[2:0];
                    CFG_COLOR_SHIFT:  regs_q.color_shift  = i_cfg_data[3:0];
                    CFG_COLOR_WIDTH:  regs_q.color_width  = i_cfg_data[4:0];
                    CFG_PENCIL_SHIFT: regs_q.pencil_shift = i_cfg_data[3:0];
                    CFG_PENCIL_WIDTH: regs_q.pencil_width = i_cfg_data[4:0];
                    CFG_START_ATTR: begin
                        regs_q.start_attribute = i_cfg_data;
                        attr_q                 = i_cfg_data;
                    end
                    default: ;
                endcase
            end
            if (i_byte_valid && i_byte_ready) begin
                predict_byte(i_in_byte);
            end
            if (i_pix_valid && i_pix_ready) begin
                if (pixels_owed.size() == 0) begin
                    $error("unexpected result: pixel_value %0h repeat_count %0h row_done %0b",
                           i_pixel_value, i_repeat_count, i_row_done);
                    fail_count++;
                end else begin
                    want = pixels_owed.pop_front();
                    check_field("pixel_value", want.pixel_value, i_pixel_value);
                    check_field("repeat_count", want.repeat_count, i_repeat_count);
                    check_field("row_done", want.row_done, i_row_done);
                    check_field("decode_error", want.decode_error, i_decode_error);
                    check_field("last_of_item", want.last_of_item, i_last_of_item);
                    checked_n++;
                end
            end
        end
        pending_n = pixels_owed.size();
    end

endmodule

@@ bench/nibble_rle_pixel16_decoder_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the nibble RLE pixel decoder: clock, reset, register writes and compressed
// byte streams; scoring is done by nrle_decode_checker. Depends on nrle_pkg, nrle_channels and the decoder top.
module nibble_rle_pixel16_decoder_top_tb;
    import nrle_pkg::*;

    localparam int       IDLE_PCT     = 15;
    localparam int       DRAIN_CYCLES = 10;
    localparam int       RUN_LIMIT_NS = 2_000_000;
    localparam t_cfg_idx CFG_SPARE_LO = 3'd6;
    localparam t_cfg_idx CFG_SPARE_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm = 1'b0;

    nrle_byte_if byte_bus ();
    nrle_cfg_if  cfg_bus ();
    nrle_pix_if  pix_bus ();

    logic [3:0] nib_q[$];
    int         fail_count;
    int         pending_n;
    int         checked_n;
    int         bytes_sent = 0;
    int         settings_n = 1;

    nibble_rle_pixel16_decoder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_bus),
        .i_cfg   (cfg_bus),
        .o_pix   (pix_bus)
    );

    nrle_decode_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_valid   (byte_bus.valid),
        .i_byte_ready   (byte_bus.ready),
        .i_in_byte      (byte_bus.in_byte),
        .i_cfg_valid    (cfg_bus.valid),
        .i_cfg_ready    (cfg_bus.ready),
        .i_cfg_index    (cfg_bus.reg_index),
        .i_cfg_data     (cfg_bus.wr_data),
        .i_pix_valid    (pix_bus.valid),
        .i_pix_ready    (pix_bus.ready),
        .i_pixel_value  (pix_bus.pixel_value),
        .i_repeat_count (pix_bus.repeat_count),
        .i_row_done     (pix_bus.row_done),
        .i_decode_error (pix_bus.decode_error),
        .i_last_of_item (pix_bus.last_of_item),
        .o_fail_count   (fail_count),
        .o_pending      (pending_n),
        .o_checked      (checked_n)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result side at random, except in the calm stretch
    always @(negedge i_clk) begin
        pix_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Hard stop if the decoder hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Present one byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] value);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            byte_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_bus.valid   <= 1'b1;
        byte_bus.in_byte <= value;
        @(posedge i_clk);
        while (!byte_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // Pack the queued nibbles high first and send them
    task automatic send_stream();
        logic [3:0] hi;
        logic [3:0] lo;
        if (nib_q.size() % 2 == 1) begin
            nib_q.push_back(4'($urandom_range(0, 14)));
        end
        while (nib_q.size() >= 2) begin
            hi = nib_q.pop_front();
            lo = nib_q.pop_front();
            send_byte({hi, lo});
        end
        byte_bus.valid <= 1'b0;
    endtask

    // Hold until every owed result is out, then let the pipeline settle
    task automatic wait_drain();
        while (pending_n != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= idx;
        cfg_bus.wr_data   <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write all six registers, plus one write to an unmapped index
    task automatic set_config(input logic [15:0] tone, input logic [15:0] col_sh,
                              input logic [15:0] col_w, input logic [15:0] pen_sh,
                              input logic [15:0] pen_w, input logic [15:0] start_attr);
        write_reg(t_cfg_idx'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 16'($urandom));
        write_reg(CFG_TONE_WIDTH, tone);
        write_reg(CFG_COLOR_SHIFT, col_sh);
        write_reg(CFG_COLOR_WIDTH, col_w);
        write_reg(CFG_PENCIL_SHIFT, pen_sh);
        write_reg(CFG_PENCIL_WIDTH, pen_w);
        write_reg(CFG_START_ATTR, start_attr);
        cfg_bus.valid <= 1'b0;
        @(negedge i_clk);
        settings_n++;
    endtask

    // Pad after a row end so the dropped low nibble is random filler
    task automatic close_row();
        if (nib_q.size() % 2 == 1) begin
            nib_q.push_back(4'($urandom));
        end
    endtask

    // Append one well-formed command or pixel, a bad escape selector, or a little noise
    task automatic add_token();
        int         pick;
        int         k;
        logic [3:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            nib_q.push_back(4'($urandom_range(0, 14)));
        end else if (pick < 48) begin
            nib_q.push_back(NIB_PREFIX);
            nib_q.push_back(CMD_ONE_MAX);
        end else if (pick < 60) begin
            k = $urandom_range(1, CMD_RUN_MAX);
            nib_q.push_back(NIB_PREFIX);
            nib_q.push_back(4'(k));
            repeat (k) nib_q.push_back(4'($urandom));
        end else if (pick < 64) begin
            nib_q.push_back(NIB_PREFIX);
            nib_q.push_back($urandom_range(0, 1) ? CMD_CLR_COL : CMD_CLR_PEN);
        end else if (pick < 74) begin
            cmd = CMD_SET_COL1 + 4'($urandom_range(0, 3));
            nib_q.push_back(NIB_PREFIX);
            nib_q.push_back(cmd);
            repeat ((cmd >= CMD_SET_COL2) ? 2 : 1) nib_q.push_back(4'($urandom));
        end else if (pick < 80) begin
            nib_q.push_back(NIB_PREFIX);
            nib_q.push_back(CMD_END_PIX);
            close_row();
        end else if (pick < 85) begin
            nib_q.push_back(NIB_PREFIX);
            nib_q.push_back(NIB_PREFIX);
            nib_q.push_back(SEL_END);
            close_row();
        end else if (pick < 92) begin
            nib_q.push_back(NIB_PREFIX);
            nib_q.push_back(NIB_PREFIX);
            nib_q.push_back(SEL_RAW);
            repeat (RAW_DIGITS) nib_q.push_back(4'($urandom));
            close_row();
        end else if (pick < 95) begin
            nib_q.push_back(NIB_PREFIX);
            nib_q.push_back(NIB_PREFIX);
            nib_q.push_back(4'($urandom_range(2, 15)));
            close_row();
        end else begin
            repeat (2) nib_q.push_back(4'($urandom));
        end
    endtask

    task automatic random_phase(input int n_bytes);
        while (nib_q.size() < 2 * n_bytes) add_token();
        send_stream();
        wait_drain();
    endtask

    // Stimulus
    initial begin
        i_rst_n           <= 1'b0;
        byte_bus.valid    <= 1'b0;
        byte_bus.in_byte  <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.reg_index <= '0;
        cfg_bus.wr_data   <= '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: plain pixels, every command but the one-digit pencil set, run extremes, row ends, raw and error
        nib_q = '{4'h0, 4'h0, 4'hE, 4'h1,
                  NIB_PREFIX, CMD_ONE_MAX,
                  NIB_PREFIX, 4'd1, 4'h5, 4'h3,
                  NIB_PREFIX, CMD_RUN_MAX, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'h2,
                  NIB_PREFIX, CMD_SET_COL2, 4'hA, 4'hB,
                  NIB_PREFIX, CMD_SET_PEN2, 4'h1, 4'hF,
                  NIB_PREFIX, CMD_SET_COL1, 4'h9, NIB_PREFIX, CMD_CLR_COL, 4'h0,
                  NIB_PREFIX, CMD_CLR_PEN, 4'h2, NIB_PREFIX, CMD_END_PIX, 4'h7,
                  NIB_PREFIX, NIB_PREFIX, SEL_END, 4'h5,
                  NIB_PREFIX, NIB_PREFIX, SEL_RAW, 4'hA, 4'hB, 4'hC, 4'hD, 4'h5,
                  NIB_PREFIX, NIB_PREFIX, 4'h3, 4'hC};
        send_stream();
        wait_drain();
        random_phase(150);

        // Zero widths and shifts
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_phase(120);

        // Every register at all ones; values clip to their widths
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(120);

        // Full-word fields exactly at width 16
        set_config(16'd4, 16'd0, 16'd16, 16'd0, 16'd16, 16'h1234);
        random_phase(110);

        // Random settings; one phase runs with no idling on either side
        for (int p = 0; p < 5; p++) begin
            set_config(16'($urandom), 16'($urandom_range(0, 15)),
                       16'($urandom_range(0, 16)), 16'($urandom_range(0, 15)),
                       16'($urandom_range(0, 16)), 16'($urandom));
            calm = (p == 2);
            random_phase(120);
            calm = 1'b0;
        end

        $display("Decoded %0d compressed bytes under %0d register settings.",
                 bytes_sent, settings_n);
        $display("Compared %0d results field by field against the predicted stream.",
                 checked_n);
        if (fail_count == 0 && pending_n == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ nibble_rle_pixel16_decoder_top.f @@
hdl/nrle_pkg.sv
hdl/nrle_channels.sv
hdl/nrle_front.sv
hdl/nrle_fifo.sv
hdl/nrle_back.sv
hdl/nibble_rle_pixel16_decoder_top.sv
hdl/nrle_checker.sv
bench/nrle_decode_checker.sv
bench/nibble_rle_pixel16_decoder_top_tb.sv
